/* hdl/lccc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccc_pkg: shared types and constants
// Request and result structs, sizes and request codes of the chain composer.
// ----------------------------------------------------------------------------
package lccc_pkg;

    localparam int CACHE_SLOTS = 4;
    localparam int ID_LIST_LEN = 8;
    localparam int TABLE_COUNT = 256;
    localparam int TBL         = 256;

    localparam int SLOT_W  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int LIST_W  = $clog2(ID_LIST_LEN);
    localparam int CNT_W   = $clog2(ID_LIST_LEN + 2);
    localparam int TID_W   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int UADDR_W = TID_W + 8;
    localparam int SADDR_W = SLOT_W + 8;
    localparam int LADDR_W = SLOT_W + LIST_W;

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_CHAIN = 2'd1;
    localparam logic [1:0] K_RSLOT = 2'd2;
    localparam logic [1:0] K_RUSER = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] table_id;
        logic [7:0] second_id;
        logic       last;
        logic [1:0] slot;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
    } t_req;

    typedef struct packed {
        logic       reply_kind;
        logic       is_direct;
        logic [7:0] answer_id;
        logic       hit;
        logic [7:0] read_value;
    } t_rsp;

    // wrap an 8-bit id into table range
    function automatic logic [TID_W-1:0] wrap_id(input logic [7:0] id);
        logic [8:0] w;
        w = {1'b0, id} % 9'(TABLE_COUNT);
        return w[TID_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/lccc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccc_ram: generic single port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hdl/lut_chain_compose_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lut_chain_compose_cache: byte lookup table chain composer with cache
// Holds user tables, composes chains of them into a scratch table and keeps
// a small round-robin cache of composed tables keyed by the id list.
// ----------------------------------------------------------------------------
//  channel   | signals                         | handshake
//  request   | i_start, i_req (t_req)          | taken when i_start & !o_busy
//  result    | o_valid, o_rsp (t_rsp)          | one-cycle strobe, no stall
//
//  A write is taken while idle and busy never rises. A read holds
//  busy through S_RD and S_RDOUT and strobes its result in the cycle after that.
//  A chain element passes each scratch entry through S_AP_S, S_AP_U, S_AP_W
//  (scratch read, table read, scratch write), then S_NEXT, per id applied,
//  one or two ids each. The last element adds the decision state S_FIN; unless
//  the chain has one id, a lookup of S_CMP per slot plus S_LRD and S_LCHK per
//  id compared, and on a miss S_MISS, up to ID_LIST_LEN id writes and a copy (S_CP_R, S_CP_W).
//  Reset clears control state and slot lengths only; memories are not
//  cleared. The receiver cannot stall: the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module lut_chain_compose_cache
    import lccc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDOUT, S_AP_S, S_AP_U, S_AP_W, S_NEXT, S_FIN,
        S_CMP, S_LRD, S_LCHK, S_MISS, S_LWR, S_CP_R, S_CP_W
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic   r_first, r_second;          // first id of chain, second id pending
    logic [TID_W-1:0] r_cur;            // table being applied
    logic [7:0] r_j;                    // entry sweep counter
    logic [CNT_W-1:0] r_cnt;
    logic [7:0] r_ids [ID_LIST_LEN];
    logic [CNT_W-1:0] r_len [CACHE_SLOTS];
    logic [SLOT_W-1:0] r_vic, r_s;
    logic [LIST_W-1:0] r_k;
    logic n_valid;
    t_rsp n_rsp;

    // memory ports
    logic               u_we, s_we, c_we, l_we;
    logic [UADDR_W-1:0] u_addr;
    logic [7:0]         s_addr, u_wd, s_wd, u_rd, s_rd, c_rd, l_rd, l_wd;
    logic [SADDR_W-1:0] c_addr;
    logic [LADDR_W-1:0] l_addr;
    logic [7:0]         c_wd;

    lccc_ram #(.WIDTH(8), .DEPTH(TABLE_COUNT*TBL)) u_user (
        .i_clk(i_clk), .i_we(u_we), .i_addr(u_addr), .i_wdata(u_wd), .o_rdata(u_rd));
    lccc_ram #(.WIDTH(8), .DEPTH(TBL)) u_scr (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd));
    lccc_ram #(.WIDTH(8), .DEPTH(CACHE_SLOTS*TBL)) u_slot (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(c_rd));
    lccc_ram #(.WIDTH(8), .DEPTH(CACHE_SLOTS*ID_LIST_LEN)) u_list (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wd), .o_rdata(l_rd));

    wire logic accept    = i_start && (r_state == S_IDLE);
    wire logic slot_last = (r_s == SLOT_W'(CACHE_SLOTS - 1));
    wire logic id_match  = (l_rd == r_ids[r_k]);
    wire logic list_end  = (CNT_W'(r_k) + CNT_W'(1) == r_cnt);

    assign o_busy = (r_state != S_IDLE);

    // memory port steering
    always_comb begin
        u_we = 1'b0; s_we = 1'b0; c_we = 1'b0; l_we = 1'b0;
        u_addr = {wrap_id(r_req.table_id), r_req.entry_index};
        u_wd = i_req.entry_value;
        s_addr = r_j; s_wd = u_rd;
        c_addr = {r_req.slot[SLOT_W-1:0], r_req.entry_index};
        c_wd = s_rd;
        l_addr = {r_s, r_k}; l_wd = r_ids[r_k];
        unique case (r_state)
            S_IDLE: begin
                u_we   = accept && (i_req.kind == K_WRITE);
                u_addr = {wrap_id(i_req.table_id), i_req.entry_index};
            end
            // first id copies its table, later ids index by the scratch value
            S_AP_U: u_addr = {r_cur, r_first ? r_j : s_rd};
            S_AP_W: s_we = 1'b1;
            S_LWR: begin
                l_we = 1'b1; l_addr = {r_vic, r_k};
            end
            S_CP_W: begin
                c_we = 1'b1; c_addr = {r_vic, r_j};
            end
            default: u_we = 1'b0;
        endcase
    end

    // result for the strobe of the next cycle
    always_comb begin
        n_valid = 1'b0;
        n_rsp   = '0;
        unique case (r_state)
            S_RDOUT: begin
                n_valid = 1'b1;
                n_rsp.reply_kind = 1'b1;
                if (r_req.kind == K_RUSER) n_rsp.read_value = u_rd;
                else if (32'(r_req.slot) < CACHE_SLOTS) n_rsp.read_value = c_rd;
            end
            S_FIN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_valid = 1'b1;
                    n_rsp.is_direct = 1'b1;
                    n_rsp.answer_id = r_ids[0];
                end
            end
            S_LCHK: begin
                if (id_match && list_end) begin
                    n_valid = 1'b1;
                    n_rsp.answer_id = 8'(r_s);
                    n_rsp.hit = 1'b1;
                end
            end
            S_CP_W: begin
                if (r_j == 8'd255) begin
                    n_valid = 1'b1;
                    n_rsp.answer_id = 8'(r_vic);
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_rsp <= n_rsp;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vic   <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++) r_len[i] <= '0;
        end else begin
            o_valid <= n_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_req;
                        unique case (i_req.kind)
                            K_WRITE: r_state <= S_IDLE;
                            K_CHAIN: begin
                                r_cur    <= wrap_id(i_req.table_id);
                                r_first  <= (r_cnt == '0);
                                r_second <= (i_req.second_id != 8'd0);
                                r_j      <= '0;
                                r_state  <= S_AP_S;
                            end
                            K_RSLOT, K_RUSER: r_state <= S_RD;
                        endcase
                    end
                end
                S_RD:    r_state <= S_RDOUT;
                S_RDOUT: r_state <= S_IDLE;
                // scratch read at entry j, then table read, then write back
                S_AP_S:  r_state <= S_AP_U;
                S_AP_U:  r_state <= S_AP_W;
                S_AP_W: begin
                    if (r_j == 8'd255) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_j     <= r_j + 8'd1;
                        r_state <= S_AP_S;
                    end
                end
                // record the id, then apply the second id or finish the element
                S_NEXT: begin
                    if (r_cnt < CNT_W'(ID_LIST_LEN)) r_ids[r_cnt[LIST_W-1:0]] <= 8'(r_cur);
                    if (r_cnt < CNT_W'(ID_LIST_LEN + 1)) r_cnt <= r_cnt + 1'b1;
                    r_first <= 1'b0;
                    if (r_second) begin
                        r_second <= 1'b0;
                        r_cur    <= wrap_id(r_req.second_id);
                        r_j      <= '0;
                        r_state  <= S_AP_S;
                    end else if (!r_req.last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_s     <= '0;
                        r_state <= S_CMP;
                    end
                end
                // skip slots whose length cannot match
                S_CMP: begin
                    if (r_len[r_s] == '0 || r_len[r_s] != r_cnt) begin
                        if (slot_last) r_state <= S_MISS;
                        else r_s <= r_s + 1'b1;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_LRD;
                    end
                end
                S_LRD: r_state <= S_LCHK;
                S_LCHK: begin
                    if (!id_match) begin
                        if (slot_last) begin
                            r_state <= S_MISS;
                        end else begin
                            r_s     <= r_s + 1'b1;
                            r_state <= S_CMP;
                        end
                    end else if (list_end) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LRD;
                    end
                end
                // miss: advance victim, store ids, then copy scratch
                S_MISS: begin
                    r_vic   <= (32'(r_vic) == CACHE_SLOTS - 1) ? '0 : r_vic + 1'b1;
                    r_k     <= '0;
                    r_state <= S_LWR;
                end
                S_LWR: begin
                    if (r_k == LIST_W'(ID_LIST_LEN - 1) || list_end) begin
                        r_len[r_vic] <= (r_cnt <= CNT_W'(ID_LIST_LEN)) ? r_cnt : '0;
                        r_j     <= '0;
                        r_state <= S_CP_R;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_CP_R: r_state <= S_CP_W;
                S_CP_W: begin
                    if (r_j == 8'd255) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 8'd1;
                        r_state <= S_CP_R;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lut_chain_compose_cache
// Loads a few complete user tables, then drives chains of them (short, long,
// repeated for cache hits, interleaved with writes and reads) together with
// user and slot reads. A tracker class mirrors the tables, the scratch
// composition and the slot cache, and checks every reply strobe in order.
// ----------------------------------------------------------------------------
module tb
    import lccc_pkg::*;
();

    // Mirror of the composer: user tables, scratch, slot cache, chain state.
    class lut_compose_tracker;
        byte unsigned user_tab[65536];
        bit           user_set[65536];
        byte unsigned scratch[256];
        byte unsigned slot_tab[4][256];
        bit           slot_filled[4];
        byte unsigned slot_ids[4][8];
        int           slot_len[4];
        int           victim;
        byte unsigned chain_ids[8];
        int           chain_cnt;
        t_rsp         pending_replies[$];
        int           errors, hits, misses, directs, reads;

        function new();
            victim    = 0;
            chain_cnt = 0;
            foreach (slot_len[s]) slot_len[s] = 0;
            foreach (slot_filled[s]) slot_filled[s] = 0;
        endfunction

        // Remap scratch through one table and record its id.
        function void compose(byte unsigned id);
            for (int j = 0; j < 256; j++) begin
                if (chain_cnt == 0) scratch[j] = user_tab[{id, 8'(j)}];
                else scratch[j] = user_tab[{id, scratch[j]}];
            end
            if (chain_cnt < ID_LIST_LEN) chain_ids[chain_cnt] = id;
            if (chain_cnt < ID_LIST_LEN + 1) chain_cnt++;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            int   found;
            e = '0;
            found = -1;
            case (r.kind)
                K_WRITE: begin
                    user_tab[{r.table_id, r.entry_index}] = r.entry_value;
                    user_set[{r.table_id, r.entry_index}] = 1;
                end
                K_RSLOT: begin
                    e.reply_kind = 1;
                    e.read_value = slot_tab[r.slot][r.entry_index];
                    pending_replies.push_back(e);
                    reads++;
                end
                K_RUSER: begin
                    e.reply_kind = 1;
                    e.read_value = user_tab[{r.table_id, r.entry_index}];
                    pending_replies.push_back(e);
                    reads++;
                end
                default: begin
                    compose(r.table_id);
                    if (r.second_id != 0) compose(r.second_id);
                    if (r.last) begin
                        if (chain_cnt == 1) begin
                            e.is_direct = 1;
                            e.answer_id = chain_ids[0];
                            directs++;
                        end else begin
                            for (int s = 0; s < CACHE_SLOTS && found < 0; s++) begin
                                if (slot_len[s] != 0 && slot_len[s] == chain_cnt) begin
                                    found = s;
                                    for (int k = 0; k < slot_len[s]; k++)
                                        if (slot_ids[s][k] != chain_ids[k]) found = -1;
                                end
                            end
                            if (found >= 0) begin
                                e.answer_id = 8'(found);
                                e.hit = 1;
                                hits++;
                            end else begin
                                // round-robin victim takes scratch and the id list
                                victim = (victim + 1) % CACHE_SLOTS;
                                slot_tab[victim] = scratch;
                                slot_filled[victim] = 1;
                                for (int k = 0; k < ID_LIST_LEN && k < chain_cnt; k++)
                                    slot_ids[victim][k] = chain_ids[k];
                                slot_len[victim] = (chain_cnt <= ID_LIST_LEN) ? chain_cnt : 0;
                                e.answer_id = 8'(victim);
                                misses++;
                            end
                        end
                        chain_cnt = 0;
                        pending_replies.push_back(e);
                    end
                end
            endcase
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply %p", $realtime, a);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            if (a.reply_kind !== e.reply_kind || a.is_direct !== e.is_direct ||
                a.answer_id !== e.answer_id || a.hit !== e.hit ||
                a.read_value !== e.read_value) begin
                $display("%0t: reply mismatch expected %p actual %p", $realtime, e, a);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start;
    t_req i_req;
    logic o_busy, o_valid;
    t_rsp o_rsp;

    lut_compose_tracker tracker;
    byte unsigned       full_ids[$];     // tables whose 256 entries are all written
    byte unsigned       recent[$][$];    // recent chains, replayed for hits
    bit                 no_idle;
    int                 quiet_cycles;
    int                 chains_sent;

    lut_chain_compose_cache dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every reply strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) tracker.check_result(o_rsp);
    end

    // Watchdog: count edges where neither a request nor a reply moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold the request until the block takes it, then log it.
    task automatic send(t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(7);
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        tracker.note_request(r);
    endtask

    // Random filler for fields that the request kind ignores.
    function automatic t_req noise_req(logic [1:0] kind);
        t_req r;
        r = t_req'(($bits(t_req))'({$urandom, $urandom}));
        r.kind = kind;
        return r;
    endfunction

    task automatic write_entry(byte unsigned id, byte unsigned idx, byte unsigned val);
        t_req r;
        r = noise_req(K_WRITE);
        r.table_id = id;
        r.entry_index = idx;
        r.entry_value = val;
        send(r);
    endtask

    task automatic read_user(byte unsigned id, byte unsigned idx);
        t_req r;
        r = noise_req(K_RUSER);
        r.table_id = id;
        r.entry_index = idx;
        send(r);
    endtask

    task automatic read_slot(logic [1:0] s, byte unsigned idx);
        t_req r;
        r = noise_req(K_RSLOT);
        r.slot = s;
        r.entry_index = idx;
        send(r);
    endtask

    // Split an id list into elements of one or two ids; a zero id can only lead.
    task automatic send_chain(byte unsigned ids[$], bit interleave);
        t_req r;
        int   k;
        k = 0;
        while (k < ids.size()) begin
            r = noise_req(K_CHAIN);
            r.table_id = ids[k];
            r.second_id = 0;
            k++;
            if (k < ids.size() && ids[k] != 0 && $urandom_range(1)) begin
                r.second_id = ids[k];
                k++;
            end
            r.last = (k == ids.size());
            send(r);
            if (interleave && !r.last && $urandom_range(3) == 0)
                read_user(full_ids[$urandom_range(full_ids.size() - 1)], 8'($urandom));
        end
        chains_sent++;
        recent.push_back(ids);
        if (recent.size() > 6) void'(recent.pop_front());
    endtask

    task automatic drain();
        i_start <= 0;
        @(posedge i_clk);
        while (tracker.pending_replies.size() > 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic byte unsigned pick_full();
        return full_ids[$urandom_range(full_ids.size() - 1)];
    endfunction

    initial begin
        byte unsigned ids[$];
        byte unsigned id, idx;
        int           pick, n;

        tracker = new();
        i_rst_n = 0;
        i_start = 0;
        i_req   = '0;
        no_idle = 0;
        chains_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Load complete tables so chains never touch unwritten entries.
        full_ids = '{8'd0, 8'd255, 8'd85, 8'd170};
        no_idle = 1;
        foreach (full_ids[t])
            for (int j = 0; j < 256; j++) write_entry(full_ids[t], 8'(j), 8'($urandom));
        no_idle = 0;

        // Directed: extremes, direct answers, miss then hit, long chain.
        write_entry(255, 255, 8'hff);
        write_entry(0, 0, 8'h00);
        read_user(255, 255);
        read_user(0, 0);
        send_chain('{8'd0}, 0);
        send_chain('{8'd255}, 0);
        send_chain('{8'd0, 8'd255}, 0);
        send_chain('{8'd0, 8'd255}, 0);
        send_chain('{8'd255, 8'd0, 8'd85}, 1);
        send_chain('{8'd170, 8'd85, 8'd255, 8'd0, 8'd85, 8'd170, 8'd255, 8'd0}, 0);
        send_chain('{8'd170, 8'd85, 8'd255, 8'd0, 8'd85, 8'd170, 8'd255, 8'd0}, 0);
        send_chain('{8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85,
                     8'd255}, 0);
        send_chain('{8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85, 8'd85,
                     8'd255}, 0);
        for (int s = 0; s < 4; s++) read_slot(2'(s), 8'(s * 85));
        drain();

        // Random: mostly well-formed chains, with writes and reads mixed in.
        for (int i = 0; i < 330; i++) begin
            if (i % 50 == 0) no_idle = ~no_idle;
            if (i % 110 == 109) drain();
            pick = $urandom_range(99);
            if (pick < 45) begin
                if (recent.size() > 0 && $urandom_range(2) == 0) begin
                    ids = recent[$urandom_range(recent.size() - 1)];
                end else begin
                    ids = {};
                    n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4);
                    repeat (n) ids.push_back(pick_full());
                end
                send_chain(ids, $urandom_range(1));
            end else if (pick < 65) begin
                // rewrite an entry of a complete table, or seed any table
                if ($urandom_range(1)) write_entry(pick_full(), 8'($urandom), 8'($urandom));
                else write_entry(8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                id = 8'($urandom);
                idx = 8'($urandom);
                if (!tracker.user_set[{id, idx}]) write_entry(id, idx, 8'($urandom));
                read_user(id, idx);
            end else begin
                n = $urandom_range(3);
                if (tracker.slot_filled[n]) read_slot(2'(n), 8'($urandom));
            end
        end

        i_start <= 0;
        @(posedge i_clk);
        while (tracker.pending_replies.size() > 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (tracker.pending_replies.size() > 0) begin
            $display("%0t: %0d replies never arrived", $realtime,
                     tracker.pending_replies.size());
            tracker.errors++;
        end

        $display("covered %0d chains: %0d direct, %0d cache hits, %0d misses",
                 chains_sent, tracker.directs, tracker.hits, tracker.misses);
        $display("plus %0d table reads; %0d mismatches", tracker.reads, tracker.errors);
        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* lut_chain_compose_cache.f */
hdl/lccc_pkg.sv
hdl/lccc_ram.sv
hdl/lut_chain_compose_cache.sv
tb/tb.sv
